### rtl/core/cmu_pkg.sv
// ---------------------------------------------------------------------------
// cmu_pkg
// Shared types and codes for the camera motion update core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmu_pkg;

    typedef enum logic [2:0] {
        REQ_TICK      = 3'd0,
        REQ_PAN       = 3'd1,
        REQ_ZOOM      = 3'd2,
        REQ_SET_POS   = 3'd3,
        REQ_SET_ZOOM  = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_DIV,
        S_APPLY,
        S_FIN,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_PAN_X = 3'd0,
        OP_PAN_Y = 3'd1,
        OP_ZOOM  = 3'd2,
        OP_FOL_X = 3'd3,
        OP_FOL_Y = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        FM_NONE   = 2'd0,
        FM_LOCK   = 2'd1,
        FM_SMOOTH = 2'd2
    } t_fmode;

    localparam logic [2:0] CFG_FOLLOW_MODE = 3'd0;
    localparam logic [2:0] CFG_FOLLOW_GAIN = 3'd1;
    localparam logic [2:0] CFG_BOUND_X_MIN = 3'd2;
    localparam logic [2:0] CFG_BOUND_X_MAX = 3'd3;
    localparam logic [2:0] CFG_BOUND_Y_MIN = 3'd4;
    localparam logic [2:0] CFG_BOUND_Y_MAX = 3'd5;

    // shared unit widths: 33-bit magnitude times 32-bit multiplier
    localparam int PW = 65;
    localparam int MUL_STEPS = 32;

endpackage

### rtl/core/camera_motion_update_core.sv
// ---------------------------------------------------------------------------
// camera_motion_update_core
// 2D camera pan/zoom tweens and target follow, one shared shift-add
// multiplier and restoring divider under a small sequencer.
// ---------------------------------------------------------------------------
//  channel | handshake                 | payload
//  in      | i_in_valid / o_in_stall   | req_type, tick_ms, arg, duration, zoom, follow
//  out     | o_out_valid / i_out_stall | pos_x, pos_y, zoom_out
//  cfg     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  Non-tick beats show their result the cycle after acceptance. A tick runs
//  up to five multiply-divide passes (pan x, pan y, zoom, follow x, follow y),
//  each a load, multiply, divide and apply step on the one-bit-per-cycle
//  shared unit; a tween that has run its length skips the multiply and divide.
//  Passes whose tween or follow is inactive are skipped.
//  Reset is synchronous; one beat in flight, input stalled until the result
//  beat leaves.
`timescale 1ns / 1ps

module camera_motion_update_core
    import cmu_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_req_type,
    input  logic [15:0]        i_tick_ms,
    input  logic signed [31:0] i_arg_x,
    input  logic signed [31:0] i_arg_y,
    input  logic [15:0]        i_duration_ms,
    input  logic [15:0]        i_zoom_value,
    input  logic signed [31:0] i_follow_x,
    input  logic signed [31:0] i_follow_y,
    input  logic               i_follow_valid,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic [15:0]        o_zoom_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int ONE_FX   = 1 << FRAC_BITS;
    localparam int GAIN_V   = (5 * ONE_FX > 65535) ? 65535 : 5 * ONE_FX;
    localparam int ZONE_V   = (ONE_FX > 65535) ? 65535 : ONE_FX;
    localparam int ZMIN_V   = (ONE_FX + 5) / 10;
    localparam int BOUND_V  = 9999 * ONE_FX;
    localparam int DEN_V    = 1000 * ONE_FX;
    localparam int CW       = $clog2(PW);

    localparam logic [15:0]        GAIN_RST  = 16'(GAIN_V);
    localparam logic [15:0]        ZOOM_RST  = 16'(ZONE_V);
    localparam logic [15:0]        ZOOM_MIN  = 16'(ZMIN_V);
    localparam logic signed [31:0] BOUND_RST = 32'(BOUND_V);
    localparam logic [31:0]        DEN       = 32'(DEN_V);

    // configuration
    logic [1:0]         r_mode;
    logic [15:0]        r_gain;
    logic signed [31:0] r_bxmin, r_bxmax, r_bymin, r_bymax;

    // camera state
    logic signed [31:0] r_cam_x, r_cam_y, n_cam_x, n_cam_y;
    logic [15:0]        r_zoom, n_zoom;
    logic signed [31:0] r_pfx, r_pfy, r_pgx, r_pgy, n_pfx, n_pfy, n_pgx, n_pgy;
    logic [15:0]        r_plen, n_plen, r_zfrom, n_zfrom, r_zgoal, n_zgoal;
    logic [15:0]        r_zlen, n_zlen;
    logic [16:0]        r_pel, n_pel, r_zel, n_zel;

    // tick context
    logic               r_pan_act, n_pan_act, r_zoom_act, n_zoom_act;
    logic signed [31:0] r_fx, r_fy, n_fx, n_fy;
    logic               r_fval, n_fval;
    logic [31:0]        r_k, n_k;

    // shared unit
    logic [PW-1:0]      r_mcand, n_mcand, r_acc, n_acc;
    logic [31:0]        r_mplier, n_mplier, r_div, n_div;
    logic [32:0]        r_rem, n_rem;
    logic               r_neg, n_neg;
    logic [CW-1:0]      r_cnt, n_cnt;

    t_state r_state, n_state;
    t_op    r_op, n_op;

    logic               in_acc;
    logic               op_need, op_direct;
    logic signed [32:0] opd_a;
    logic [32:0]        opd_mag;
    logic [31:0]        opd_b, opd_d;
    logic [32:0]        rem_sh;
    logic               rem_ge;
    logic signed [65:0] q_s;
    logic signed [66:0] fol_sum;
    logic signed [31:0] fol_sat, fin_x, fin_y;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cfg_ready = 1'b1;
    assign o_pos_x     = r_cam_x;
    assign o_pos_y     = r_cam_y;
    assign o_zoom_out  = r_zoom;

    // operand selection for the current pass
    always_comb begin
        op_need   = 1'b0;
        op_direct = 1'b0;
        opd_a     = '0;
        opd_b     = '0;
        opd_d     = DEN;
        unique case (r_op)
            OP_PAN_X: begin
                op_need   = r_pan_act;
                op_direct = (r_pel >= {1'b0, r_plen});
                opd_a     = 33'(r_pgx) - 33'(r_pfx);
                opd_b     = 32'(r_pel);
                opd_d     = 32'(r_plen);
            end
            OP_PAN_Y: begin
                op_need   = r_pan_act;
                op_direct = (r_pel >= {1'b0, r_plen});
                opd_a     = 33'(r_pgy) - 33'(r_pfy);
                opd_b     = 32'(r_pel);
                opd_d     = 32'(r_plen);
            end
            OP_ZOOM: begin
                op_need   = r_zoom_act;
                op_direct = (r_zel >= {1'b0, r_zlen});
                opd_a     = $signed(33'(r_zgoal)) - $signed(33'(r_zfrom));
                opd_b     = 32'(r_zel);
                opd_d     = 32'(r_zlen);
            end
            OP_FOL_X: begin
                op_need   = r_fval && (r_mode == FM_SMOOTH);
                opd_a     = 33'(r_fx) - 33'(r_cam_x);
                opd_b     = r_k;
            end
            OP_FOL_Y: begin
                op_need   = r_fval && (r_mode == FM_SMOOTH);
                opd_a     = 33'(r_fy) - 33'(r_cam_y);
                opd_b     = r_k;
            end
            default: begin
                op_need = 1'b0;
            end
        endcase
        opd_mag = opd_a[32] ? 33'(-opd_a) : 33'(opd_a);
    end

    always_comb begin
        rem_sh = {r_rem[31:0], r_acc[PW-1]};
        rem_ge = (rem_sh >= {1'b0, r_div});
        q_s    = $signed({1'b0, r_acc});
        if (r_neg) begin
            q_s = -q_s - 66'(r_rem != '0);
        end
        fol_sum = ((r_op == OP_FOL_X) ? 67'(r_cam_x) : 67'(r_cam_y)) + 67'(q_s);
        if (fol_sum > 67'sd2147483647) begin
            fol_sat = 32'sh7fffffff;
        end else if (fol_sum < -67'sd2147483648) begin
            fol_sat = 32'sh80000000;
        end else begin
            fol_sat = fol_sum[31:0];
        end
        fin_x = (r_mode == FM_LOCK) ? r_fx : r_cam_x;
        fin_y = (r_mode == FM_LOCK) ? r_fy : r_cam_y;
        if (fin_x < r_bxmin) fin_x = r_bxmin;
        if (fin_x > r_bxmax) fin_x = r_bxmax;
        if (fin_y < r_bymin) fin_y = r_bymin;
        if (fin_y > r_bymax) fin_y = r_bymax;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = (t_req'(i_req_type) == REQ_TICK) ? S_LOAD : S_OUT;
            end
            S_LOAD: begin
                if (!op_need) n_state = (r_op == OP_FOL_Y) ? S_FIN : S_LOAD;
                else if (op_direct) n_state = S_APPLY;
                else n_state = S_MUL;
            end
            S_MUL:   if (r_cnt == CW'(MUL_STEPS - 1)) n_state = S_DIV;
            S_DIV:   if (r_cnt == CW'(PW - 1)) n_state = S_APPLY;
            S_APPLY: n_state = (r_op == OP_FOL_Y) ? S_FIN : S_LOAD;
            S_FIN:   n_state = S_OUT;
            S_OUT:   if (!i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_cam_x = r_cam_x;  n_cam_y = r_cam_y;  n_zoom = r_zoom;
        n_pfx = r_pfx;  n_pfy = r_pfy;  n_pgx = r_pgx;  n_pgy = r_pgy;
        n_plen = r_plen;  n_pel = r_pel;
        n_zfrom = r_zfrom;  n_zgoal = r_zgoal;  n_zlen = r_zlen;  n_zel = r_zel;
        n_pan_act = r_pan_act;  n_zoom_act = r_zoom_act;
        n_fx = r_fx;  n_fy = r_fy;  n_fval = r_fval;  n_k = r_k;
        n_mcand = r_mcand;  n_acc = r_acc;  n_mplier = r_mplier;
        n_div = r_div;  n_rem = r_rem;  n_neg = r_neg;  n_cnt = r_cnt;
        n_op = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op = OP_PAN_X;
                    case (i_req_type)
                        REQ_TICK: begin
                            n_pan_act  = (r_plen != '0) && (r_pel < {1'b0, r_plen});
                            n_zoom_act = (r_zlen != '0) && (r_zel < {1'b0, r_zlen});
                            if (n_pan_act) n_pel = r_pel + 17'(i_tick_ms);
                            if (n_zoom_act) n_zel = r_zel + 17'(i_tick_ms);
                            n_fx   = i_follow_x;
                            n_fy   = i_follow_y;
                            n_fval = i_follow_valid;
                            n_k    = r_gain * i_tick_ms;
                        end
                        REQ_PAN: begin
                            n_pfx = r_cam_x;  n_pfy = r_cam_y;
                            n_pgx = i_arg_x;  n_pgy = i_arg_y;
                            n_plen = i_duration_ms;  n_pel = '0;
                        end
                        REQ_ZOOM: begin
                            n_zfrom = r_zoom;  n_zgoal = i_zoom_value;
                            n_zlen = i_duration_ms;  n_zel = '0;
                        end
                        REQ_SET_POS: begin
                            n_cam_x = i_arg_x;  n_cam_y = i_arg_y;
                        end
                        REQ_SET_ZOOM: begin
                            n_zoom = (i_zoom_value < ZOOM_MIN) ? ZOOM_MIN : i_zoom_value;
                        end
                        default: begin
                            n_cam_x = r_cam_x;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                n_mcand  = PW'(opd_mag);
                n_mplier = opd_b;
                n_div    = opd_d;
                n_neg    = opd_a[32];
                n_acc    = '0;
                n_rem    = '0;
                n_cnt    = '0;
                if (!op_need && r_op != OP_FOL_Y) n_op = t_op'(r_op + 3'd1);
            end
            S_MUL: begin
                if (r_mplier[0]) n_acc = r_acc + r_mcand;
                n_mcand  = {r_mcand[PW-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[31:1]};
                n_cnt    = (r_cnt == CW'(MUL_STEPS - 1)) ? '0 : r_cnt + CW'(1);
            end
            S_DIV: begin
                n_rem = rem_ge ? rem_sh - {1'b0, r_div} : rem_sh;
                n_acc = {r_acc[PW-2:0], rem_ge};
                n_cnt = r_cnt + CW'(1);
            end
            S_APPLY: begin
                unique case (r_op)
                    OP_PAN_X: n_cam_x = op_direct ? r_pgx : r_pfx + q_s[31:0];
                    OP_PAN_Y: n_cam_y = op_direct ? r_pgy : r_pfy + q_s[31:0];
                    OP_ZOOM:  n_zoom  = op_direct ? r_zgoal : r_zfrom + q_s[15:0];
                    OP_FOL_X: n_cam_x = fol_sat;
                    OP_FOL_Y: n_cam_y = fol_sat;
                    default:  n_zoom  = r_zoom;
                endcase
                if (r_op != OP_FOL_Y) n_op = t_op'(r_op + 3'd1);
            end
            S_FIN: begin
                if (r_mode != FM_NONE && r_fval) begin
                    n_cam_x = fin_x;
                    n_cam_y = fin_y;
                end
            end
            default: begin
                n_op = r_op;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_op       <= OP_PAN_X;
            r_cam_x    <= '0;
            r_cam_y    <= '0;
            r_zoom     <= ZOOM_RST;
            r_pfx      <= '0;  r_pfy <= '0;  r_pgx <= '0;  r_pgy <= '0;
            r_plen     <= '0;  r_pel <= '0;
            r_zfrom    <= '0;  r_zgoal <= '0;  r_zlen <= '0;  r_zel <= '0;
            r_pan_act  <= 1'b0;
            r_zoom_act <= 1'b0;
            r_fval     <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_op       <= n_op;
            r_cam_x    <= n_cam_x;
            r_cam_y    <= n_cam_y;
            r_zoom     <= n_zoom;
            r_pfx      <= n_pfx;  r_pfy <= n_pfy;  r_pgx <= n_pgx;  r_pgy <= n_pgy;
            r_plen     <= n_plen;  r_pel <= n_pel;
            r_zfrom    <= n_zfrom;  r_zgoal <= n_zgoal;  r_zlen <= n_zlen;  r_zel <= n_zel;
            r_pan_act  <= n_pan_act;
            r_zoom_act <= n_zoom_act;
            r_fval     <= n_fval;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fx     <= n_fx;
        r_fy     <= n_fy;
        r_k      <= n_k;
        r_mcand  <= n_mcand;
        r_acc    <= n_acc;
        r_mplier <= n_mplier;
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_neg    <= n_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= FM_NONE;
            r_gain  <= GAIN_RST;
            r_bxmin <= -BOUND_RST;
            r_bxmax <= BOUND_RST;
            r_bymin <= -BOUND_RST;
            r_bymax <= BOUND_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FOLLOW_MODE: r_mode  <= i_cfg_data[1:0];
                CFG_FOLLOW_GAIN: r_gain  <= i_cfg_data[15:0];
                CFG_BOUND_X_MIN: r_bxmin <= i_cfg_data;
                CFG_BOUND_X_MAX: r_bxmax <= i_cfg_data;
                CFG_BOUND_Y_MIN: r_bymin <= i_cfg_data;
                CFG_BOUND_Y_MAX: r_bymax <= i_cfg_data;
                default:         r_mode  <= r_mode;
            endcase
        end
    end

endmodule

### rtl/core/cmu_checker.sv
// ---------------------------------------------------------------------------
// cmu_checker
// Port-level checks for the camera motion update core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_pos_x,
    input logic signed [31:0] o_pos_y,
    input logic [15:0]        o_zoom_out
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            ($stable(o_pos_x) && $stable(o_pos_y) && $stable(o_zoom_out)))
        else $error("result payload changed while stalled");

    a_busy_on_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a result waits");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_in_stall && !$past(o_out_valid)))
        else $error("input not stalled after accepted beat");

endmodule

bind camera_motion_update_core cmu_checker u_cmu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_pos_x     (o_pos_x),
    .o_pos_y     (o_pos_y),
    .o_zoom_out  (o_zoom_out)
);
